[rtl/core/rhc_pkg.sv]
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types, constants and divider step functions for the RGB to HSV unit.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int CH_W       = 8;
	localparam int HUE_W      = 9;
	localparam int NUM_W      = 2 * CH_W;
	localparam int DIV_STAGES = CH_W;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
	localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;
	localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
	localparam logic [NUM_W-1:0] HUE_SCALE = 16'd60;
	localparam logic [NUM_W-1:0] SAT_SCALE = 16'd255;

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

	typedef struct packed {
		max_sel_t           sel;
		logic               neg;
		logic               grey;
		logic [CH_W-1:0]    mx;
	} side_t;

	// restoring divider lane: partial remainder, numerator bits still to
	// shift in, quotient bits so far
	typedef struct packed {
		logic [CH_W-1:0] rem;
		logic [CH_W-1:0] num;
		logic [CH_W-1:0] quo;
	} lane_t;

	typedef struct packed {
		lane_t           hue;
		lane_t           sat;
		logic [CH_W-1:0] delta;
		side_t           side;
	} div_word_t;

	// numerator is below divisor * 2^CH_W whenever the divisor is nonzero, so the
	// high half is a valid starting remainder
	function automatic lane_t lane_init(logic [NUM_W-1:0] n);
		lane_t o;
		o.rem = n[NUM_W-1:CH_W];
		o.num = n[CH_W-1:0];
		o.quo = '0;
		return o;
	endfunction

	function automatic lane_t lane_step(lane_t l, logic [CH_W-1:0] d);
		logic [CH_W:0] t;
		lane_t         o;
		t     = {l.rem, l.num[CH_W-1]};
		o.num = {l.num[CH_W-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			o.rem = CH_W'(t - {1'b0, d});
			o.quo = {l.quo[CH_W-2:0], 1'b1};
		end else begin
			o.rem = t[CH_W-1:0];
			o.quo = {l.quo[CH_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic div_word_t div_step(div_word_t w);
		div_word_t o;
		o     = w;
		o.hue = lane_step(w.hue, w.delta);
		o.sat = lane_step(w.sat, w.side.mx);
		return o;
	endfunction

endpackage

[rtl/core/rhc_divider.sv]
// ----------------------------------------------------------------------------
// rhc_divider
// Pipelined two-lane restoring divider, one quotient bit per stage, with
// per-stage valid and back-pressure; side data rides along.
// ----------------------------------------------------------------------------
module rhc_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rhc_pkg::div_word_t in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output rhc_pkg::div_word_t out_word
);
	import rhc_pkg::*;

	logic [DIV_STAGES:0]   rdy;
	logic [DIV_STAGES-1:0] vin;
	logic [DIV_STAGES-1:0] vld_s;
	div_word_t             win   [DIV_STAGES];
	div_word_t             word_s[DIV_STAGES];

	assign rdy[DIV_STAGES] = out_ready;
	assign in_ready        = rdy[0];
	assign out_valid       = vld_s[DIV_STAGES-1];
	assign out_word        = word_s[DIV_STAGES-1];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		if (i == 0) begin : g_first
			assign vin[i] = in_valid;
			assign win[i] = in_word;
		end else begin : g_next
			assign vin[i] = vld_s[i-1];
			assign win[i] = word_s[i-1];
		end

		assign rdy[i] = !vld_s[i] || rdy[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				vld_s[i] <= vin[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && vin[i]) begin
				word_s[i] <= div_step(win[i]);
			end
		end
	end

endmodule

[rtl/core/rgb_to_hsv_converter_unit.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// RGB pixel in, hue in whole degrees, saturation and value out.
// ----------------------------------------------------------------------------
// Takes one pixel per clock when the output side does not stall and returns
// one HSV result per pixel, in order, after these registered stages:
// one stage for max/min and channel difference, one for the scaled
// numerators, eight for the shared-shape restoring dividers (one quotient bit
// each) and one output register. Every stage holds its own valid bit, so
// empty stages fill while the output waits.
module rgb_to_hsv_converter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rhc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // red, green, blue
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [rhc_pkg::OUT_DATA_W-1:0] m_axis_tdata   // hue, saturation, brightness
);
	import rhc_pkg::*;

	logic [CH_W-1:0] red, green, blue;
	logic [CH_W-1:0] mx, mn;
	max_sel_t        sel;
	logic [CH_W:0]   diff;

	logic            vld_s1;
	logic [CH_W-1:0] mx_s1, mn_s1;
	max_sel_t        sel_s1;
	logic [CH_W:0]   diff_s1;

	logic            vld_s2;
	div_word_t       word_s2;
	div_word_t       word_d;
	logic [CH_W-1:0] delta;
	logic [CH_W:0]   diff_neg;
	logic [CH_W-1:0] absd;
	logic            neg;

	logic            rdy_s1, rdy_s2, rdy_out, div_in_ready;
	logic            div_valid;
	div_word_t       div_word;

	logic [HUE_W-1:0] q;
	logic [HUE_W-1:0] hue;
	logic [CH_W-1:0]  sat;
	logic             out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign red   = s_axis_tdata[CH_W-1:0];
	assign green = s_axis_tdata[2*CH_W-1:CH_W];
	assign blue  = s_axis_tdata[3*CH_W-1:2*CH_W];

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (red == mx) begin
			sel  = SEL_RED;
			diff = {1'b0, green} - {1'b0, blue};
		end else if (green == mx) begin
			sel  = SEL_GREEN;
			diff = {1'b0, blue} - {1'b0, red};
		end else begin
			sel  = SEL_BLUE;
			diff = {1'b0, red} - {1'b0, green};
		end
	end

	// handshake chain, output side first
	assign rdy_out       = !out_vld_q || m_axis_tready;
	assign rdy_s2        = !vld_s2 || div_in_ready;
	assign rdy_s1        = !vld_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_axis_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_out) out_vld_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			mx_s1   <= mx;
			mn_s1   <= mn;
			sel_s1  <= sel;
			diff_s1 <= diff;
		end
	end

	// stage 2: delta, |diff| and the two scaled numerators
	always_comb begin
		delta    = mx_s1 - mn_s1;
		neg      = diff_s1[CH_W];
		diff_neg = (CH_W+1)'(0) - diff_s1;
		absd     = neg ? diff_neg[CH_W-1:0] : diff_s1[CH_W-1:0];
		word_d.hue       = lane_init(NUM_W'({{CH_W{1'b0}}, absd} * HUE_SCALE));
		word_d.sat       = lane_init(NUM_W'({{CH_W{1'b0}}, delta} * SAT_SCALE));
		word_d.delta     = delta;
		word_d.side.sel  = sel_s1;
		word_d.side.neg  = neg;
		word_d.side.grey = (delta == '0);
		word_d.side.mx   = mx_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			word_s2 <= word_d;
		end
	end

	rhc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (div_in_ready),
		.in_word   (word_s2),
		.out_valid (div_valid),
		.out_ready (rdy_out),
		.out_word  (div_word)
	);

	// final hue offset and wrap; saturation forced to zero when the max is zero
	always_comb begin
		q = {1'b0, div_word.hue.quo};
		case (div_word.side.sel)
			SEL_RED: begin
				if (div_word.side.neg && q != '0) hue = HUE_FULL - q;
				else hue = div_word.side.neg ? '0 : q;
			end
			SEL_GREEN: hue = div_word.side.neg ? HUE_GREEN - q : HUE_GREEN + q;
			SEL_BLUE:  hue = div_word.side.neg ? HUE_BLUE - q : HUE_BLUE + q;
			default:   hue = '0;
		endcase
		if (div_word.side.grey) hue = '0;
		sat = (div_word.side.mx == '0) ? '0 : div_word.sat.quo;
	end

	always_ff @(posedge clk) begin
		if (rdy_out && div_valid) begin
			out_data_q <= {(OUT_DATA_W-HUE_W-2*CH_W)'(0), div_word.side.mx, sat, hue};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

[tb/rhc_hsv_checker.sv]
// ----------------------------------------------------------------------------
// rhc_hsv_checker
// Watches both stream ports of the RGB to HSV unit and checks every result.
// ----------------------------------------------------------------------------
// Each accepted pixel beat is converted to hue, saturation and value in
// integer arithmetic and queued. Each accepted result beat is compared field
// by field against the oldest queued entry. Mismatches and results arriving
// with nothing queued are counted. The first ten are also reported.
module rhc_hsv_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [rhc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [rhc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output int                             mismatches,
	output int                             pending
);
	import rhc_pkg::*;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat;
		logic [CH_W-1:0]  val;
	} hsv_t;

	hsv_t hsv_due[$];

	function automatic hsv_t hsv_of_pixel(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
			logic [CH_W-1:0] blue);
		int   r, g, b, mx, mn, d, h, s;
		hsv_t o;
		r  = int'(red);
		g  = int'(green);
		b  = int'(blue);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		h = 0;
		s = 0;
		if (d != 0) begin
			// first channel equal to the max wins a tie
			if (r == mx) begin
				h = (60 * (g - b)) / d;
			end else if (g == mx) begin
				h = 120 + (60 * (b - r)) / d;
			end else begin
				h = 240 + (60 * (r - g)) / d;
			end
			if (h < 0) h += 360;
		end
		if (mx != 0) s = (d * 255) / mx;
		o.hue = HUE_W'(h);
		o.sat = CH_W'(s);
		o.val = CH_W'(mx);
		return o;
	endfunction

	always @(posedge clk) begin
		hsv_t got, want;
		if (!arst_n) begin
			mismatches = 0;
			pending    <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				hsv_due.push_back(hsv_of_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8],
					s_axis_tdata[23:16]));
			if (m_axis_tvalid && m_axis_tready) begin
				got.hue = m_axis_tdata[8:0];
				got.sat = m_axis_tdata[16:9];
				got.val = m_axis_tdata[24:17];
				if (hsv_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: hue %0d sat %0d val %0d",
							got.hue, got.sat, got.val);
				end else begin
					want = hsv_due.pop_front();
					if (got.hue !== want.hue || got.sat !== want.sat ||
							got.val !== want.val) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected hue %0d sat %0d val %0d, ",
								"got hue %0d sat %0d val %0d"},
								want.hue, want.sat, want.val,
								got.hue, got.sat, got.val);
					end
				end
			end
			pending <= hsv_due.size();
		end
	end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the RGB to HSV converter unit.
// ----------------------------------------------------------------------------
// Drives directed corner pixels (black, white, grey, primaries, tied maxima,
// a hue that truncates to zero from below) and then three random phases with
// different source and sink idling. Between phases the source waits for the
// pipeline to drain. Checking is done by rhc_hsv_checker.
module tb_top;
	import rhc_pkg::*;

	localparam int LIMIT = 200000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // red, green, blue
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // hue, saturation, brightness
	int                    mismatches;
	int                    pending;
	int                    src_idle_pct = 0;
	int                    sink_idle_pct = 0;
	int                    cycle_cnt = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rgb_to_hsv_converter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	rhc_hsv_checker hsv_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always @(posedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("rgb_to_hsv_converter_unit test failed");
			$finish;
		end
	end

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, g, r};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || hsv_chk.hsv_due.size() != 0) @(posedge clk);
	endtask

	task automatic random_pixel;
		logic [7:0] r, g, b, base;
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		case ($urandom_range(5))
			0: begin
				// near grey: small delta
				base = 8'($urandom);
				r = base ^ 8'($urandom_range(3));
				g = base ^ 8'($urandom_range(3));
				b = base ^ 8'($urandom_range(3));
			end
			1: begin
				// two channels tied
				case ($urandom_range(2))
					0: g = r;
					1: b = g;
					default: b = r;
				endcase
			end
			2: begin
				r = 8'($urandom_range(7));
				g = 8'($urandom_range(7));
				b = 8'($urandom_range(7));
			end
			default: ;
		endcase
		send_pixel(r, g, b);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 13;
		sink_idle_pct = 70;
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd255);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd1,   8'd1,   8'd0);
		send_pixel(8'd255, 8'd1,   8'd254);
		send_pixel(8'd1,   8'd255, 8'd254);
		send_pixel(8'd254, 8'd1,   8'd255);
		send_pixel(8'd170, 8'd85,  8'd170);
		send_pixel(8'd85,  8'd170, 8'd85);
		send_pixel(8'd2,   8'd1,   8'd0);
		drain();

		for (int i = 0; i < 630; i++) random_pixel();
		drain();

		src_idle_pct  = 70;
		sink_idle_pct = 13;
		for (int i = 0; i < 630; i++) random_pixel();
		drain();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		for (int i = 0; i < 630; i++) random_pixel();
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("rgb_to_hsv_converter_unit test passed");
		end else begin
			$display("rgb_to_hsv_converter_unit test failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/rhc_pkg.sv
rtl/core/rhc_divider.sv
rtl/core/rgb_to_hsv_converter_unit.sv
tb/rhc_hsv_checker.sv
tb/tb_top.sv
